// ===== rtl/core/bitmap_store_with_find_core_defines.svh =====
// Assertion macros for the bitmap store core.
// Needs signals named clock and reset in the including module.
`ifndef BITMAP_STORE_WITH_FIND_CORE_DEFINES_SVH
`define BITMAP_STORE_WITH_FIND_CORE_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define BSF_ASSERT_IMP(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// antecedent implies consequent in the next cycle
`define BSF_ASSERT_NXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/bsf_pkg.sv =====
// Shared types and constants for the bitmap store core.
// No dependencies.
package bsf_pkg;

   localparam int NUM_BLOCKS = 32;
   localparam int WORD_W     = 64;
   localparam int BLK_W      = 5;
   localparam int OFF_W      = 6;
   localparam int OP_W       = 4;
   localparam int POS_W      = 11;
   localparam int RPOS_W     = 12;
   localparam int CNT_W      = 12;
   localparam int USED_W     = 6;

   localparam logic [OP_W-1:0] OP_SET       = 4'd0;
   localparam logic [OP_W-1:0] OP_RESET     = 4'd1;
   localparam logic [OP_W-1:0] OP_TEST      = 4'd2;
   localparam logic [OP_W-1:0] OP_FIRST_SET = 4'd3;
   localparam logic [OP_W-1:0] OP_NEXT_SET  = 4'd4;
   localparam logic [OP_W-1:0] OP_FIRST_CLR = 4'd5;
   localparam logic [OP_W-1:0] OP_NEXT_CLR  = 4'd6;
   localparam logic [OP_W-1:0] OP_COUNT     = 4'd7;
   localparam logic [OP_W-1:0] OP_CLEAR     = 4'd8;

   typedef struct packed {
      logic [OP_W-1:0]  operation;
      logic [POS_W-1:0] bit_index;
   } req_type;

   typedef struct packed {
      logic              bit_value;
      logic              found;
      logic [RPOS_W-1:0] result_position;
      logic [CNT_W-1:0]  set_count;
      logic [USED_W-1:0] used_blocks;
   } rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic start;     // latch request, preset result fields and scan pointer
      logic clear;     // drop every block
      logic rd_idx;    // read the addressed block
      logic modify;    // set / reset / test on the block just read
      logic issue;     // scan: read block at pointer, step pointer
      logic eval;      // scan: evaluate block in read register
      logic rsp_load;  // copy result fields to output register
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic shrink;      // current op is reset, scan runs downward
      logic more;        // pointer still inside scan range
      logic rd_pending;  // read register holds a scanned block
      logic stop;        // evaluated block ends the scan
      logic last;        // evaluated block is the last in range
   } sts_type;

endpackage

// ===== rtl/core/bsf_datapath.sv =====
// Datapath: block memory with valid bits, scan pointer, find/count units
// and result registers. Depends on bsf_pkg.
module bsf_datapath (
   input  logic             clock,
   input  logic             reset,
   input  bsf_pkg::req_type req_payload,
   input  bsf_pkg::cmd_type cmd,
   output bsf_pkg::sts_type sts,
   output bsf_pkg::rsp_type rsp_payload
);
   import bsf_pkg::*;

   function automatic logic [OFF_W-1:0] low_set(input logic [WORD_W-1:0] w);
      logic [OFF_W-1:0] r;
      r = '0;
      for (int i = WORD_W - 1; i >= 0; i--) begin
         if (w[i]) r = OFF_W'(i);
      end
      return r;
   endfunction

   function automatic logic [OFF_W:0] ones(input logic [WORD_W-1:0] w);
      logic [OFF_W:0] c;
      c = '0;
      for (int i = 0; i < WORD_W; i++) begin
         c = c + {{OFF_W{1'b0}}, w[i]};
      end
      return c;
   endfunction

   logic [WORD_W-1:0]     mem [NUM_BLOCKS];
   logic [NUM_BLOCKS-1:0] blk_vld_ff;
   logic [USED_W-1:0]     used_ff;
   logic [OP_W-1:0]       op_ff;
   logic [POS_W-1:0]      pos_ff;
   logic [USED_W-1:0]     ptr_ff;
   logic [WORD_W-1:0]     rd_data_ff;
   logic [BLK_W-1:0]      rd_blk_ff;
   logic                  rd_vld_ff;
   logic                  bitv_ff;
   logic                  found_ff;
   logic [RPOS_W-1:0]     rpos_ff;
   logic [CNT_W-1:0]      cnt_ff;
   rsp_type               rsp_ff;

   logic [BLK_W-1:0]  idx;
   logic [OFF_W-1:0]  off;
   logic [BLK_W-1:0]  req_idx;
   logic              fwd;
   logic [USED_W-1:0] ptr_dec;
   logic [BLK_W-1:0]  issue_addr;
   logic [BLK_W-1:0]  rd_addr;
   logic              rd_en;
   logic              wr_en;
   logic [WORD_W-1:0] wr_data;
   logic [WORD_W-1:0] mask;
   logic [WORD_W-1:0] bit_sel;
   logic [WORD_W-1:0] word_m;
   logic [WORD_W-1:0] srch;
   logic              hit;
   logic              clr_find;
   logic              next_op;

   assign idx      = pos_ff[POS_W-1:OFF_W];
   assign off      = pos_ff[OFF_W-1:0];
   assign req_idx  = req_payload.bit_index[POS_W-1:OFF_W];
   assign fwd      = (op_ff != OP_RESET);
   assign ptr_dec  = ptr_ff - USED_W'(1);
   assign issue_addr = fwd ? ptr_ff[BLK_W-1:0] : ptr_dec[BLK_W-1:0];
   assign rd_addr  = cmd.rd_idx ? idx : issue_addr;
   assign rd_en    = cmd.rd_idx | cmd.issue;
   // bits at and below the offset; all ones at offset 63 pushes the search on
   assign mask     = (WORD_W'(2) << off) - WORD_W'(1);
   assign bit_sel  = WORD_W'(1) << off;
   assign clr_find = (op_ff == OP_FIRST_CLR) || (op_ff == OP_NEXT_CLR);
   assign next_op  = (op_ff == OP_NEXT_SET) || (op_ff == OP_NEXT_CLR);
   assign wr_en    = cmd.modify && ((op_ff == OP_SET) || (op_ff == OP_RESET));
   assign wr_data  = (op_ff == OP_SET) ? (rd_data_ff | bit_sel) : (rd_data_ff & ~bit_sel);

   always_comb begin
      word_m = rd_data_ff;
      if (rd_blk_ff == idx) begin
         case (op_ff)
            OP_NEXT_SET: word_m = rd_data_ff & ~mask;
            OP_NEXT_CLR: word_m = rd_data_ff | mask;
            default:     word_m = rd_data_ff;
         endcase
      end
   end

   assign srch = clr_find ? ~word_m : word_m;
   assign hit  = |srch;

   always_comb begin
      sts.shrink     = ~fwd;
      sts.more       = fwd ? (ptr_ff < used_ff) : (ptr_ff != '0);
      sts.rd_pending = rd_vld_ff;
      sts.last       = fwd ? (({1'b0, rd_blk_ff} + USED_W'(1)) == used_ff)
                           : (rd_blk_ff == '0);
      case (op_ff)
         OP_FIRST_SET, OP_NEXT_SET, OP_FIRST_CLR, OP_NEXT_CLR: sts.stop = hit;
         OP_RESET: sts.stop = |rd_data_ff;
         default:  sts.stop = 1'b0;
      endcase
   end

   // block memory, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[idx] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= blk_vld_ff[rd_addr] ? mem[rd_addr] : '0;
         rd_blk_ff  <= rd_addr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         blk_vld_ff <= '0;
         used_ff    <= '0;
         rd_vld_ff  <= 1'b0;
      end else begin
         rd_vld_ff <= cmd.issue;
         if (cmd.clear) begin
            blk_vld_ff <= '0;
            used_ff    <= '0;
         end
         if (wr_en) begin
            blk_vld_ff[idx] <= 1'b1;
         end
         if (cmd.modify && (op_ff == OP_SET) && ({1'b0, idx} >= used_ff)) begin
            used_ff <= {1'b0, idx} + USED_W'(1);
         end
         // compaction: a zero top block drops the count to its index
         if (cmd.eval && (op_ff == OP_RESET) && !(|rd_data_ff)) begin
            used_ff <= {1'b0, rd_blk_ff};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         op_ff   <= req_payload.operation;
         pos_ff  <= req_payload.bit_index;
         bitv_ff <= 1'b0;
         cnt_ff  <= '0;
         if ((req_payload.operation == OP_NEXT_SET) ||
             (req_payload.operation == OP_NEXT_CLR)) begin
            ptr_ff <= {1'b0, req_idx};
         end else begin
            ptr_ff <= '0;
         end
         case (req_payload.operation)
            OP_FIRST_CLR: begin
               found_ff <= 1'b1;
               rpos_ff  <= {used_ff, {OFF_W{1'b0}}};
            end
            OP_NEXT_CLR: begin
               found_ff <= 1'b1;
               if ({1'b0, req_idx} >= used_ff) begin
                  rpos_ff <= {1'b0, req_payload.bit_index} + RPOS_W'(1);
               end else begin
                  rpos_ff <= {used_ff, {OFF_W{1'b0}}};
               end
            end
            default: begin
               found_ff <= 1'b0;
               rpos_ff  <= '0;
            end
         endcase
      end else begin
         if (cmd.modify) begin
            if (op_ff == OP_TEST) begin
               bitv_ff <= rd_data_ff[off];
            end
            if (op_ff == OP_RESET) begin
               ptr_ff <= used_ff;
            end
         end
         if (cmd.issue) begin
            ptr_ff <= fwd ? (ptr_ff + USED_W'(1)) : ptr_dec;
         end
         if (cmd.eval) begin
            if (op_ff == OP_COUNT) begin
               cnt_ff <= cnt_ff + CNT_W'(ones(rd_data_ff));
            end
            if (hit && (clr_find || next_op || (op_ff == OP_FIRST_SET))) begin
               found_ff <= 1'b1;
               rpos_ff  <= {1'b0, rd_blk_ff, low_set(srch)};
            end
         end
      end
      if (cmd.rsp_load) begin
         rsp_ff.bit_value       <= bitv_ff;
         rsp_ff.found           <= found_ff;
         rsp_ff.result_position <= rpos_ff;
         rsp_ff.set_count       <= cnt_ff;
         rsp_ff.used_blocks     <= used_ff;
      end
   end

   assign rsp_payload = rsp_ff;

endmodule

// ===== rtl/core/bsf_ctrl.sv =====
// Controller state machine: sequences accept, block access, scans and
// result transfer. Depends on bsf_pkg.
module bsf_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [bsf_pkg::OP_W-1:0] req_op,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   input  bsf_pkg::sts_type sts,
   output bsf_pkg::cmd_type cmd
);
   import bsf_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_ACCESS,
      S_MODIFY,
      S_SCAN,
      S_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      scan_done;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign scan_done = sts.rd_pending && (sts.stop || sts.last);

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.start = 1'b1;
               case (req_op)
                  OP_SET, OP_RESET, OP_TEST: state_in = S_ACCESS;
                  OP_FIRST_SET, OP_NEXT_SET, OP_FIRST_CLR, OP_NEXT_CLR,
                  OP_COUNT: state_in = S_SCAN;
                  OP_CLEAR: begin
                     cmd.clear = 1'b1;
                     state_in  = S_FINISH;
                  end
                  default: state_in = S_FINISH;
               endcase
            end
         end
         S_ACCESS: begin
            cmd.rd_idx = 1'b1;
            state_in   = S_MODIFY;
         end
         S_MODIFY: begin
            cmd.modify = 1'b1;
            state_in   = sts.shrink ? S_SCAN : S_FINISH;
         end
         S_SCAN: begin
            // reads run one block ahead of evaluation
            cmd.eval  = sts.rd_pending;
            cmd.issue = sts.more && !scan_done;
            if (scan_done || (!sts.rd_pending && !sts.more)) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== rtl/core/bitmap_store_with_find_core.sv =====
// Top level of the bitmap store with find-first-set / find-first-clear.
// Depends on bsf_pkg, bsf_ctrl, bsf_datapath and the defines header.
//
//   channel | direction | ports
//   --------+-----------+----------------------------------------
//   request | in        | req_valid, req_ready, req_payload
//   result  | out       | rsp_valid, rsp_ready, rsp_payload
//
// One item at a time. Clear and unknown codes go from acceptance straight to
// the result step; set and test read the addressed block, then modify it;
// reset then also reads blocks downward for compaction (each dropped block and
// the nonzero block that stops it). Finds and count scan blocks through the
// single memory read port, one per cycle.
// Reset is synchronous and needs no memory sweep (per-block valid bits).
// A held result stalls only the end of the next item, not its acceptance.
`include "bitmap_store_with_find_core_defines.svh"

module bitmap_store_with_find_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  bsf_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output bsf_pkg::rsp_type rsp_payload
);
   import bsf_pkg::*;

   cmd_type cmd;
   sts_type sts;

   bsf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_op    (req_payload.operation),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   bsf_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .cmd         (cmd),
      .sts         (sts),
      .rsp_payload (rsp_payload)
   );

   `BSF_ASSERT_IMP(a_no_rsp_overwrite, cmd.rsp_load, !rsp_valid || rsp_ready, "result overwritten before transfer")
   `BSF_ASSERT_NXT(a_busy_after_accept, req_valid && req_ready, !req_ready, "request taken while busy")
   `BSF_ASSERT_IMP(a_eval_after_issue, cmd.eval, $past(cmd.issue), "scan evaluate without a read")
   `BSF_ASSERT_IMP(a_used_in_range, rsp_valid, rsp_payload.used_blocks <= USED_W'(NUM_BLOCKS), "used block count out of range")

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for bitmap_store_with_find_core: directed table, then random ops.
// Expected results come from a bit-level shadow of the bitmap kept here.
// Depends on bsf_pkg and the core RTL.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import bsf_pkg::*;

   localparam logic [OP_W-1:0] OP_UNDEF_LO = 4'd9;
   localparam logic [OP_W-1:0] OP_UNDEF_HI = 4'd15;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_payload;

   bitmap_store_with_find_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   always #5ns clock = ~clock;

   // shadow copy of the bitmap
   logic [WORD_W-1:0] shadow_blocks [NUM_BLOCKS];
   int                shadow_used;

   rsp_type bitmap_answers [$];
   int      mismatch_cnt = 0;
   int      tx_idle_pct = 26;
   int      rx_idle_pct = 26;

   typedef struct packed {
      req_type req;
      logic    fixed;
      rsp_type rsp;
   } dir_row_type;

   // fixed rows carry the result by hand; others use the shadow
   dir_row_type dir_table [25] = '{
      '{'{OP_TEST,      11'd0},    1'b1, '{1'b0, 1'b0, 12'd0,    12'd0, 6'd0}},
      '{'{OP_COUNT,     11'd0},    1'b1, '{1'b0, 1'b0, 12'd0,    12'd0, 6'd0}},
      '{'{OP_FIRST_SET, 11'd0},    1'b1, '{1'b0, 1'b0, 12'd0,    12'd0, 6'd0}},
      '{'{OP_FIRST_CLR, 11'd0},    1'b1, '{1'b0, 1'b1, 12'd0,    12'd0, 6'd0}},
      '{'{OP_NEXT_CLR,  11'd2047}, 1'b1, '{1'b0, 1'b1, 12'd2048, 12'd0, 6'd0}},
      '{'{OP_NEXT_SET,  11'd0},    1'b1, '{1'b0, 1'b0, 12'd0,    12'd0, 6'd0}},
      '{'{OP_RESET,     11'd5},    1'b1, '{1'b0, 1'b0, 12'd0,    12'd0, 6'd0}},
      '{'{OP_SET,       11'd2047}, 1'b1, '{1'b0, 1'b0, 12'd0,    12'd0, 6'd32}},
      '{'{OP_TEST,      11'd2047}, 1'b1, '{1'b1, 1'b0, 12'd0,    12'd0, 6'd32}},
      '{'{OP_FIRST_SET, 11'd0},    1'b1, '{1'b0, 1'b1, 12'd2047, 12'd0, 6'd32}},
      '{'{OP_NEXT_SET,  11'd2047}, 1'b1, '{1'b0, 1'b0, 12'd0,    12'd0, 6'd32}},
      '{'{OP_NEXT_CLR,  11'd2046}, 1'b1, '{1'b0, 1'b1, 12'd2048, 12'd0, 6'd32}},
      '{'{OP_COUNT,     11'd0},    1'b1, '{1'b0, 1'b0, 12'd0,    12'd1, 6'd32}},
      '{'{OP_SET,       11'd0},    1'b0, '0},
      '{'{OP_SET,       11'd63},   1'b0, '0},
      '{'{OP_SET,       11'd64},   1'b0, '0},
      '{'{OP_NEXT_SET,  11'd63},   1'b0, '0},
      '{'{OP_NEXT_SET,  11'd0},    1'b0, '0},
      '{'{OP_NEXT_CLR,  11'd62},   1'b0, '0},
      '{'{OP_RESET,     11'd2047}, 1'b0, '0},
      '{'{OP_TEST,      11'd1024}, 1'b0, '0},
      '{'{OP_UNDEF_LO,  11'd2047}, 1'b1, '{1'b0, 1'b0, 12'd0,    12'd0, 6'd2}},
      '{'{OP_UNDEF_HI,  11'd0},    1'b1, '{1'b0, 1'b0, 12'd0,    12'd0, 6'd2}},
      '{'{OP_CLEAR,     11'd2047}, 1'b1, '{1'b0, 1'b0, 12'd0,    12'd0, 6'd0}},
      '{'{OP_TEST,      11'd63},   1'b1, '{1'b0, 1'b0, 12'd0,    12'd0, 6'd0}}
   };

   function automatic int lowest_one(logic [WORD_W-1:0] w);
      for (int i = 0; i < WORD_W; i++)
         if (w[i]) return i;
      return WORD_W;
   endfunction

   // first set (or clear) bit in blocks first..used-1, -1 when none
   function automatic int scan_blocks(int first, bit want_clear);
      int b;
      for (int i = first; i < shadow_used; i++) begin
         b = lowest_one(want_clear ? ~shadow_blocks[i] : shadow_blocks[i]);
         if (b < WORD_W) return i * WORD_W + b;
      end
      return -1;
   endfunction

   function automatic rsp_type apply_bitmap_op(req_type r);
      rsp_type           o;
      int                blk;
      int                off;
      int                p;
      int                b;
      logic [WORD_W-1:0] upto;
      o    = '0;
      blk  = int'(r.bit_index[POS_W-1:OFF_W]);
      off  = int'(r.bit_index[OFF_W-1:0]);
      p    = -1;
      upto = (64'd2 << off) - 64'd1;   // bits 0..off
      case (r.operation)
         OP_SET: begin
            if (blk < NUM_BLOCKS) begin
               shadow_blocks[blk][off] = 1'b1;
               if (blk >= shadow_used) shadow_used = blk + 1;
            end
         end
         OP_RESET: begin
            if (blk < shadow_used) begin
               shadow_blocks[blk][off] = 1'b0;
               while (shadow_used > 0 && shadow_blocks[shadow_used-1] == '0)
                  shadow_used--;
            end
         end
         OP_TEST: begin
            if (blk < shadow_used) o.bit_value = shadow_blocks[blk][off];
         end
         OP_FIRST_SET: p = scan_blocks(0, 1'b0);
         OP_NEXT_SET: begin
            if (blk < shadow_used) begin
               if (off < WORD_W - 1) begin
                  b = lowest_one(shadow_blocks[blk] & ~upto);
                  if (b < WORD_W) p = blk * WORD_W + b;
               end
               if (p < 0) p = scan_blocks(blk + 1, 1'b0);
            end
         end
         OP_FIRST_CLR: begin
            p = scan_blocks(0, 1'b1);
            if (p < 0) p = shadow_used * WORD_W;
         end
         OP_NEXT_CLR: begin
            if (blk >= shadow_used) begin
               p = int'(r.bit_index) + 1;
            end else begin
               if (off < WORD_W - 1) begin
                  b = lowest_one(~(shadow_blocks[blk] | upto));
                  if (b < WORD_W) p = blk * WORD_W + b;
               end
               if (p < 0) p = scan_blocks(blk + 1, 1'b1);
               if (p < 0) p = shadow_used * WORD_W;
            end
         end
         OP_COUNT: begin
            for (int i = 0; i < shadow_used; i++)
               o.set_count += CNT_W'($countones(shadow_blocks[i]));
         end
         OP_CLEAR: begin
            for (int i = 0; i < NUM_BLOCKS; i++) shadow_blocks[i] = '0;
            shadow_used = 0;
         end
         default: ;
      endcase
      if (p >= 0) begin
         o.found           = 1'b1;
         o.result_position = p[RPOS_W-1:0];
      end
      o.used_blocks = shadow_used[USED_W-1:0];
      return o;
   endfunction

   // called at a falling edge; returns at the falling edge after the transfer
   task automatic send_op(input logic [OP_W-1:0] op, input logic [POS_W-1:0] idx,
                          input bit use_fixed = 1'b0, input rsp_type fixed = '0);
      req_type r;
      rsp_type predicted;
      r.operation = op;
      r.bit_index = idx;
      while ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= r;
      do @(posedge clock); while (!req_ready);
      predicted = apply_bitmap_op(r);
      bitmap_answers.push_back(use_fixed ? fixed : predicted);
      @(negedge clock);
   endtask

   // bias toward the first and last blocks and toward block-edge offsets
   function automatic logic [POS_W-1:0] pick_index();
      int               sel;
      logic [BLK_W-1:0] blk;
      logic [OFF_W-1:0] off;
      sel = $urandom_range(99);
      blk = BLK_W'($urandom);
      off = OFF_W'($urandom);
      if (sel < 45)
         blk = ($urandom_range(1) ? 5'd0 : 5'd29) + BLK_W'($urandom_range(2));
      else if (sel < 65)
         off = ($urandom_range(2) == 0) ? 6'd0 : 6'd62 + OFF_W'($urandom_range(1));
      return {blk, off};
   endfunction

   function automatic logic [OP_W-1:0] pick_op();
      int w;
      w = $urandom_range(99);
      if (w < 30) return OP_SET;
      if (w < 45) return OP_RESET;
      if (w < 57) return OP_TEST;
      if (w < 63) return OP_FIRST_SET;
      if (w < 73) return OP_NEXT_SET;
      if (w < 78) return OP_FIRST_CLR;
      if (w < 88) return OP_NEXT_CLR;
      if (w < 93) return OP_COUNT;
      if (w < 95) return OP_CLEAR;
      return OP_W'($urandom_range(OP_UNDEF_LO, OP_UNDEF_HI));
   endfunction

   always @(negedge clock)
      rsp_ready <= ($urandom_range(99) >= rx_idle_pct);

   always @(posedge clock) begin : check_results
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (bitmap_answers.size() == 0) begin
            $display("%0t: result with nothing expected: %p", $time, rsp_payload);
            mismatch_cnt++;
         end else begin
            want = bitmap_answers.pop_front();
            if (rsp_payload.bit_value       !== want.bit_value       ||
                rsp_payload.found           !== want.found           ||
                rsp_payload.result_position !== want.result_position ||
                rsp_payload.set_count       !== want.set_count       ||
                rsp_payload.used_blocks     !== want.used_blocks) begin
               $display("%0t: mismatch expected bit=%0d found=%0d pos=%0d cnt=%0d used=%0d",
                        $time, want.bit_value, want.found, want.result_position,
                        want.set_count, want.used_blocks);
               $display("%0t:          actual   bit=%0d found=%0d pos=%0d cnt=%0d used=%0d",
                        $time, rsp_payload.bit_value, rsp_payload.found,
                        rsp_payload.result_position, rsp_payload.set_count,
                        rsp_payload.used_blocks);
               mismatch_cnt++;
            end
         end
      end
   end

   initial begin
      #5ms;
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin : stimulus
      int n_rand;
      int fills;
      int nfull;
      n_rand = 0;
      fills  = 0;
      for (int i = 0; i < NUM_BLOCKS; i++) shadow_blocks[i] = '0;
      shadow_used = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (dir_table[k])
         send_op(dir_table[k].req.operation, dir_table[k].req.bit_index,
                 dir_table[k].fixed, dir_table[k].rsp);

      while (n_rand < 800) begin
         // a stretch with no idling on either side
         tx_idle_pct = (n_rand >= 300 && n_rand < 450) ? 0 : 26;
         rx_idle_pct = tx_idle_pct;
         if (fills < 3 && n_rand >= 150 + fills * 220) begin
            // fill the low blocks completely so that clear finds run off the end
            nfull = (fills == 1) ? 2 : 1;
            send_op(OP_CLEAR, POS_W'($urandom));
            for (int b = 0; b < nfull; b++)
               for (int o = 0; o < WORD_W; o++)
                  send_op(OP_SET, {BLK_W'(b), OFF_W'(o)});
            send_op(OP_FIRST_CLR, POS_W'($urandom));
            send_op(OP_NEXT_CLR, {BLK_W'($urandom_range(nfull - 1)), OFF_W'($urandom)});
            send_op(OP_COUNT, POS_W'($urandom));
            send_op(OP_NEXT_SET, {BLK_W'(0), OFF_W'($urandom)});
            send_op(OP_RESET, {BLK_W'($urandom_range(nfull - 1)), OFF_W'($urandom)});
            send_op(OP_FIRST_CLR, POS_W'($urandom));
            send_op(OP_NEXT_CLR, {BLK_W'(0), OFF_W'($urandom)});
            n_rand += nfull * WORD_W + 8;
            fills++;
         end else begin
            send_op(pick_op(), pick_index());
            n_rand++;
         end
      end

      req_valid <= 1'b0;
      while (bitmap_answers.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (mismatch_cnt == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
